// ===== rtl/core/sfrx_pkg.sv =====
// Shared types and constants for the sync frame receive filter.
// No dependencies.
package sfrx_pkg;
  localparam int NodeSlotsDef = 8;
  localparam logic [1:0] CfgOwnSlot = 2'd0;
  localparam logic [1:0] CfgEpoch   = 2'd1;
  localparam logic [1:0] CfgRun     = 2'd2;

  localparam logic [2:0] RxAccept   = 3'd0;
  localparam logic [2:0] RxInvalid  = 3'd1;
  localparam logic [2:0] RxBadSrc   = 3'd2;
  localparam logic [2:0] RxTgtMiss  = 3'd3;
  localparam logic [2:0] RxEpochMis = 3'd4;
  localparam logic [2:0] RxDup      = 3'd5;
  localparam logic [2:0] RxStale    = 3'd6;

  localparam logic [7:0] KindHello = 8'd0;
  localparam logic [7:0] KindEpoch = 8'd1;
  localparam logic [7:0] KindDelta = 8'd2;
  localparam logic [3:0] MaxDeltaWidth = 4'd4;

  // Classified item handed from front to back.
  typedef struct packed {
    logic [2:0]  code;      // front-end verdict, RxAccept means go to peer check
    logic [1:0]  status;
    logic [2:0]  peer;
    logic [7:0]  kind;
    logic [31:0] seq;
    logic [31:0] check;
    logic [15:0] dslot;
    logic [15:0] doff;
    logic [3:0]  dwidth;
    logic [31:0] dbytes;
  } item_t;
endpackage

// ===== rtl/core/sfrx_front.sv =====
// Front stage: registers config, classifies header checks, queues the word.
// Depends on sfrx_pkg.
module sfrx_front #(
  parameter int NODE_SLOTS = sfrx_pkg::NodeSlotsDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 take,
  input  logic [1:0]           frame_status,
  input  logic [7:0]           src_slot,
  input  logic [7:0]           tgt_mask,
  input  logic [7:0]           frame_kind,
  input  logic [31:0]          epoch_field,
  input  logic [31:0]          run_field,
  input  logic [31:0]          seq_number,
  input  logic [31:0]          payload_check,
  input  logic [15:0]          delta_slot,
  input  logic [15:0]          delta_offset,
  input  logic [3:0]           delta_width,
  input  logic [31:0]          delta_bytes,
  output sfrx_pkg::item_t      item,
  output logic                 item_valid
);
  logic [2:0]  own_r;
  logic [31:0] epoch_r, run_r;
  logic [2:0]  code;
  sfrx_pkg::item_t item_nxt, item_r;
  logic        vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r <= '0; epoch_r <= '0; run_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfrx_pkg::CfgOwnSlot: own_r   <= cfg_data[2:0];
        sfrx_pkg::CfgEpoch:   epoch_r <= cfg_data;
        sfrx_pkg::CfgRun:     run_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_status != 2'd0) code = sfrx_pkg::RxInvalid;
    else if ({24'd0, src_slot} >= 32'(NODE_SLOTS)) code = sfrx_pkg::RxBadSrc;
    else if ({29'd0, own_r} >= 32'(NODE_SLOTS) || !tgt_mask[own_r])
      code = sfrx_pkg::RxTgtMiss;
    else if (frame_kind != sfrx_pkg::KindHello &&
             (epoch_field != epoch_r || run_field != run_r))
      code = sfrx_pkg::RxEpochMis;
    else code = sfrx_pkg::RxAccept;
  end

  always_comb begin
    item_nxt.code = code; item_nxt.status = frame_status; item_nxt.peer = src_slot[2:0];
    item_nxt.kind = frame_kind; item_nxt.seq = seq_number; item_nxt.check = payload_check;
    item_nxt.dslot = delta_slot; item_nxt.doff = delta_offset;
    item_nxt.dwidth = delta_width; item_nxt.dbytes = delta_bytes;
  end

  // one-entry queue toward the back stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0; item_r <= '0;
    end else begin
      vld_r <= take;
      if (take) item_r <= item_nxt;
    end
  end

  assign item       = item_r;
  assign item_valid = vld_r;
endmodule

// ===== rtl/core/sfrx_back.sv =====
// Back stage: peer table read-modify-write, mirror and quality counters.
// Depends on sfrx_pkg.
module sfrx_back #(
  parameter int NODE_SLOTS = sfrx_pkg::NodeSlotsDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  sfrx_pkg::item_t  item,
  output logic             done,
  output logic [2:0]       rx_code,
  output logic [31:0]      gap_count,
  output logic             mirror_written,
  output logic [31:0]      peer_frames
);
  logic [7:0]  seen_r, hello_r, epseen_r;
  logic [31:0] last_r [8];
  logic [31:0] exp_r  [8];
  logic [7:0]  lkind_r [8];
  logic [31:0] lchk_r [8];
  logic [31:0] cnt_r [8][4];
  logic [63:0] ment_r [8];
  logic [63:0] mdat_r [8];
  logic [63:0] mcnt_r [8];
  logic [31:0] q_r [11];

  logic [2:0]  code;
  logic [31:0] diff, gap, val;
  logic        wr, acc;
  logic [2:0]  p;

  assign p = item.peer;

  always_comb begin
    code = item.code; gap = '0; wr = 1'b0;
    diff = item.seq - last_r[p];
    if (code == sfrx_pkg::RxAccept && seen_r[p]) begin
      if (diff == '0) code = sfrx_pkg::RxDup;
      else if (diff[31]) code = sfrx_pkg::RxStale;
      else if (item.seq > exp_r[p]) gap = item.seq - exp_r[p];
    end
    acc = (code == sfrx_pkg::RxAccept);
    wr = acc && item.kind == sfrx_pkg::KindDelta && item.dwidth <= sfrx_pkg::MaxDeltaWidth;
    case (item.dwidth)
      4'd0: val = '0;
      4'd1: val = {24'd0, item.dbytes[7:0]};
      4'd2: val = {16'd0, item.dbytes[15:0]};
      4'd3: val = {8'd0, item.dbytes[23:0]};
      default: val = item.dbytes;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0; hello_r <= '0; epseen_r <= '0; done <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        last_r[i] <= '0; exp_r[i] <= '0; lkind_r[i] <= '0; lchk_r[i] <= '0;
        ment_r[i] <= '0; mdat_r[i] <= '0; mcnt_r[i] <= '0;
        for (int k = 0; k < 4; k++) cnt_r[i][k] <= '0;
      end
      for (int j = 0; j < 11; j++) q_r[j] <= '0;
    end else begin
      done <= go;
      if (go) begin
        rx_code <= code; gap_count <= gap; mirror_written <= wr;
        peer_frames <= (code == sfrx_pkg::RxAccept) ? cnt_r[p][0] + 32'd1 :
                       (code == sfrx_pkg::RxDup || code == sfrx_pkg::RxStale) ?
                       cnt_r[p][0] : 32'd0;
        q_r[0] <= q_r[0] + 32'd1;
        unique case (code)
          sfrx_pkg::RxInvalid: begin
            q_r[1] <= q_r[1] + 32'd1;
            if (item.status == 2'd1) q_r[2] <= q_r[2] + 32'd1;
            else q_r[3] <= q_r[3] + 32'd1;
          end
          sfrx_pkg::RxBadSrc:   q_r[4] <= q_r[4] + 32'd1;
          sfrx_pkg::RxTgtMiss:  q_r[5] <= q_r[5] + 32'd1;
          sfrx_pkg::RxEpochMis: q_r[6] <= q_r[6] + 32'd1;
          sfrx_pkg::RxDup: begin
            q_r[7] <= q_r[7] + 32'd1; cnt_r[p][1] <= cnt_r[p][1] + 32'd1;
          end
          sfrx_pkg::RxStale: begin
            q_r[8] <= q_r[8] + 32'd1; cnt_r[p][2] <= cnt_r[p][2] + 32'd1;
          end
          default: begin
            q_r[9] <= q_r[9] + gap; q_r[10] <= q_r[10] + 32'd1;
            cnt_r[p][3] <= cnt_r[p][3] + gap;
            cnt_r[p][0] <= cnt_r[p][0] + 32'd1;
            seen_r[p] <= 1'b1;
            if (item.kind == sfrx_pkg::KindHello) hello_r[p] <= 1'b1;
            else if (item.kind == sfrx_pkg::KindEpoch) epseen_r[p] <= 1'b1;
            last_r[p] <= item.seq; exp_r[p] <= item.seq + 32'd1;
            lkind_r[p] <= item.kind; lchk_r[p] <= item.check;
            if (wr) begin
              ment_r[p] <= {12'd0, item.dwidth, item.doff, item.dslot, 15'd0, 1'b1};
              mdat_r[p] <= {item.check, val};
              mcnt_r[p] <= {mcnt_r[p][63:32] + 32'd1, item.seq};
            end
          end
        endcase
      end
    end
  end

  // Accepted frames always land in the peer table.
  a_seen: assert property (@(posedge clk) disable iff (!rst_n)
    go && code == sfrx_pkg::RxAccept |=> seen_r[$past(p)]) else $error("seen");
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    done && rx_code != sfrx_pkg::RxAccept |-> gap_count == '0) else $error("gap");
  a_wr: assert property (@(posedge clk) disable iff (!rst_n)
    done && mirror_written |-> rx_code == sfrx_pkg::RxAccept) else $error("wr");

  logic unused;
  assign unused = ^{hello_r, epseen_r, NODE_SLOTS[0]};
endmodule

// ===== rtl/core/sync_frame_rx_filter_top.sv =====
// Top level of the sync frame receive filter.
// Depends on sfrx_pkg, sfrx_front, sfrx_back.
// Pipeline: a taken start is registered in the front queue register and then
// in the back stage, whose registered result strobes out_valid.
// Throughput: one frame per cycle; busy is always low (peer table in flops).
// Reset: synchronous active-low clears config, peer table, mirror, counters.
// The receiver cannot stall; out_valid pulses for one cycle per item.
module sync_frame_rx_filter_top #(
  parameter int NODE_SLOTS = sfrx_pkg::NodeSlotsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_frame_status,
  input  logic [7:0]  in_source_slot,
  input  logic [7:0]  in_target_mask,
  input  logic [7:0]  in_frame_kind,
  input  logic [31:0] in_epoch_field,
  input  logic [31:0] in_run_field,
  input  logic [31:0] in_seq_number,
  input  logic [31:0] in_payload_check,
  input  logic [15:0] in_delta_slot,
  input  logic [15:0] in_delta_offset,
  input  logic [3:0]  in_delta_width,
  input  logic [31:0] in_delta_bytes,
  output logic        out_valid,
  output logic [2:0]  out_rx_code,
  output logic [31:0] out_gap_count,
  output logic        out_mirror_written,
  output logic [31:0] out_peer_frames
);
  sfrx_pkg::item_t item;
  logic take;
  logic fq_valid;

  assign busy = 1'b0;
  assign take = start & ~busy;

  // Front: config registers, header classification, one-word queue.
  sfrx_front #(.NODE_SLOTS(NODE_SLOTS)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .take,
    .frame_status(in_frame_status), .src_slot(in_source_slot),
    .tgt_mask(in_target_mask), .frame_kind(in_frame_kind),
    .epoch_field(in_epoch_field), .run_field(in_run_field),
    .seq_number(in_seq_number), .payload_check(in_payload_check),
    .delta_slot(in_delta_slot), .delta_offset(in_delta_offset),
    .delta_width(in_delta_width), .delta_bytes(in_delta_bytes), .item,
    .item_valid(fq_valid));

  // Back: peer sequence checks and table update, registered result.
  sfrx_back #(.NODE_SLOTS(NODE_SLOTS)) u_back (
    .clk, .rst_n, .go(fq_valid), .item, .done(out_valid),
    .rx_code(out_rx_code), .gap_count(out_gap_count),
    .mirror_written(out_mirror_written), .peer_frames(out_peer_frames));
endmodule
